[rtl/audio_pwm_playback_sequencer_macros.svh]
// Assertion helpers for the playback sequencer.
`ifndef AUDIO_PWM_PLAYBACK_SEQUENCER_MACROS_SVH
`define AUDIO_PWM_PLAYBACK_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define APPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define APPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define APPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define APPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/apps_pkg.sv]
`timescale 1ns / 1ps

package apps_pkg;

	// Command codes
	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_START  = 3'd1,
		OP_WRITE  = 3'd2,
		OP_COMMIT = 3'd3,
		OP_STOP   = 3'd4
	} op_t;

	// Configuration register indexes
	typedef enum logic [0:0] {
		CFG_STARTUP  = 1'b0,
		CFG_SHUTDOWN = 1'b1
	} cfg_idx_t;

	// Where the duty of a result comes from
	typedef enum logic [1:0] {
		DUTY_HOLD,
		DUTY_MID,
		DUTY_FLASH,
		DUTY_MEM
	} duty_sel_t;

	localparam logic [7:0]  MID_SCALE      = 8'd128;
	localparam logic [15:0] STARTUP_RESET  = 16'd1333;
	localparam logic [15:0] SHUTDOWN_RESET = 16'd8000;

	// Per-item status handed from control to the result pipeline
	typedef struct packed {
		duty_sel_t   duty_sel;
		logic [7:0]  flash;
		logic        reload;
		logic        amp_off;
		logic        playing;
		logic        ticking;
		logic [31:0] position;
	} step_t;

endpackage

[rtl/apps_cmd_if.sv]
`timescale 1ns / 1ps

interface apps_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic        source;
	logic [31:0] stream_size;
	logic [7:0]  flash_sample;
	logic        bank;
	logic [8:0]  index;
	logic [7:0]  value;

	modport source_mp (
		output valid, op, source, stream_size, flash_sample, bank, index, value,
		input  ready
	);
	modport sink (
		input  valid, op, source, stream_size, flash_sample, bank, index, value,
		output ready
	);
endinterface

[rtl/apps_res_if.sv]
`timescale 1ns / 1ps

interface apps_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  duty;
	logic        amp_shutdown;
	logic        playing;
	logic        reload_request;
	logic [31:0] position;
	logic        ticking;

	modport source_mp (
		output valid, duty, amp_shutdown, playing, reload_request, position, ticking,
		input  ready
	);
	modport sink (
		input  valid, duty, amp_shutdown, playing, reload_request, position, ticking,
		output ready
	);
endinterface

[rtl/apps_bank_mem.sv]
`timescale 1ns / 1ps

module apps_bank_mem import apps_pkg::*; #(
	parameter int AW = 9
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW:0]   waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW:0]   raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [0:(2**(AW+1))-1];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; hold data between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/apps_ctrl.sv]
`timescale 1ns / 1ps

module apps_ctrl import apps_pkg::*; #(
	parameter int BANK_DEPTH = 512
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic [2:0]                        op,
	input  logic                              source,
	input  logic [31:0]                       stream_size,
	input  logic [7:0]                        flash_sample,
	input  logic                              bank,
	input  logic [8:0]                        index,
	input  logic [7:0]                        value,
	input  logic                              cfg_we,
	input  logic [0:0]                        cfg_index,
	input  logic [15:0]                       cfg_wdata,
	output step_t                             step,
	output logic                              mem_we,
	output logic [$clog2(BANK_DEPTH):0]       mem_waddr,
	output logic [7:0]                        mem_wdata,
	output logic                              mem_re,
	output logic [$clog2(BANK_DEPTH):0]       mem_raddr
);

	localparam int AW = $clog2(BANK_DEPTH);
	localparam int PW = AW + 1;
	localparam int IW = (PW > 9) ? PW : 9;
	localparam logic [PW-1:0] DEPTH_P = PW'(BANK_DEPTH);
	localparam logic [IW-1:0] DEPTH_I = IW'(BANK_DEPTH);

	// Configuration
	logic [15:0] startup_ticks_q, shutdown_ticks_q;

	// Sequencer state
	logic [15:0]   startup_cnt_q, startup_cnt_d;
	logic [15:0]   shutdown_cnt_q, shutdown_cnt_d;
	logic [31:0]   played_q, played_d;
	logic [31:0]   limit_q, limit_d;
	logic          src_q, src_d;
	logic          playing_q, playing_d;
	logic          amp_off_q, amp_off_d;
	logic          tick_en_q, tick_en_d;
	logic          active_q, active_d;
	logic [PW-1:0] rpos_q [2];
	logic [PW-1:0] rpos_d [2];

	logic [PW-1:0] cur_pos;
	logic [PW-1:0] pos_inc;
	logic [IW-1:0] idx_w;
	duty_sel_t     duty_sel;
	logic          reload;

	assign cur_pos = rpos_q[active_q];
	assign pos_inc = cur_pos + 1'b1;
	assign idx_w   = IW'(index);

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			startup_ticks_q  <= STARTUP_RESET;
			shutdown_ticks_q <= SHUTDOWN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_STARTUP:  startup_ticks_q  <= cfg_wdata;
				CFG_SHUTDOWN: shutdown_ticks_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Decode the item and work out the next state
	always_comb begin
		startup_cnt_d  = startup_cnt_q;
		shutdown_cnt_d = shutdown_cnt_q;
		played_d       = played_q;
		limit_d        = limit_q;
		src_d          = src_q;
		playing_d      = playing_q;
		amp_off_d      = amp_off_q;
		tick_en_d      = tick_en_q;
		active_d       = active_q;
		rpos_d         = rpos_q;
		duty_sel       = DUTY_HOLD;
		reload         = 1'b0;
		mem_we         = 1'b0;

		unique case (op_t'(op))
			OP_TICK: begin
				if (tick_en_q) begin
					if (startup_cnt_q < startup_ticks_q) begin
						duty_sel       = DUTY_MID;
						startup_cnt_d  = startup_cnt_q + 16'd1;
						shutdown_cnt_d = 16'd0;
					end else if (played_q < limit_q) begin
						shutdown_cnt_d = 16'd0;
						if (!src_q) begin
							duty_sel = DUTY_FLASH;
							played_d = played_q + 32'd1;
						end else if (cur_pos < DEPTH_P) begin
							duty_sel          = DUTY_MEM;
							played_d          = played_q + 32'd1;
							rpos_d[active_q]  = pos_inc;
							if (pos_inc == DEPTH_P) begin
								active_d = ~active_q;
								reload   = 1'b1;
							end
						end
					end else if (shutdown_cnt_q < shutdown_ticks_q) begin
						duty_sel       = DUTY_MID;
						shutdown_cnt_d = shutdown_cnt_q + 16'd1;
						playing_d      = 1'b0;
					end else begin
						tick_en_d      = 1'b0;
						amp_off_d      = 1'b1;
						startup_cnt_d  = 16'd0;
						shutdown_cnt_d = 16'd0;
						playing_d      = 1'b0;
					end
				end
			end
			OP_START: begin
				played_d  = 32'd0;
				playing_d = 1'b1;
				limit_d   = stream_size;
				src_d     = source;
				if (source) begin
					rpos_d[0] = DEPTH_P;
					rpos_d[1] = DEPTH_P;
					active_d  = 1'b0;
				end
				amp_off_d = 1'b0;
				tick_en_d = 1'b1;
			end
			OP_WRITE: begin
				mem_we = idx_w < DEPTH_I;
			end
			OP_COMMIT: begin
				rpos_d[bank] = '0;
			end
			OP_STOP: begin
				if (playing_q) begin
					limit_d = 32'd0;
				end
			end
			default: ;
		endcase
	end

	// Drive memory ports and item status
	always_comb begin
		mem_waddr     = {bank, idx_w[AW-1:0]};
		mem_wdata     = value;
		mem_re        = accept && (duty_sel == DUTY_MEM);
		mem_raddr     = {active_q, cur_pos[AW-1:0]};
		step.duty_sel = duty_sel;
		step.flash    = flash_sample;
		step.reload   = reload;
		step.amp_off  = amp_off_d;
		step.playing  = playing_d;
		step.ticking  = tick_en_d;
		step.position = played_d;
	end

	// Commit state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			startup_cnt_q  <= 16'd0;
			shutdown_cnt_q <= 16'd0;
			played_q       <= 32'd0;
			src_q          <= 1'b0;
			playing_q      <= 1'b0;
			amp_off_q      <= 1'b1;
			tick_en_q      <= 1'b0;
			active_q       <= 1'b0;
			rpos_q[0]      <= '0;
			rpos_q[1]      <= '0;
		end else if (accept) begin
			startup_cnt_q  <= startup_cnt_d;
			shutdown_cnt_q <= shutdown_cnt_d;
			played_q       <= played_d;
			src_q          <= src_d;
			playing_q      <= playing_d;
			amp_off_q      <= amp_off_d;
			tick_en_q      <= tick_en_d;
			active_q       <= active_d;
			rpos_q         <= rpos_d;
		end
	end

	// Stream length is written by start before any use
	always_ff @(posedge clk) begin
		if (accept) begin
			limit_q <= limit_d;
		end
	end

	// The write port and read port never serve the same item, and a byte written
	// by one item is visible to a read issued by the next.
	// Bank address modulo the depth comes from the low bits of the position.

endmodule

[rtl/audio_pwm_playback_sequencer.sv]
// Channel | Dir  | Handshake     | Payload
// cmd     | sink | valid / ready | op, source, stream_size, flash_sample, bank, index, value
// result  | src  | valid / ready | duty, amp_shutdown, playing, reload_request, position, ticking
// cfg     | sink | cfg_we        | cfg_index, cfg_wdata
//
// One command item is taken per cycle while cmd.ready is high; its result passes through
// the bank memory read stage and then the output register.
// Reset clears the control state except the stream length, which start writes before
// any use; the sample banks are not cleared.
// A stall on result holds the output register, then the read stage, then drops cmd.ready.
`timescale 1ns / 1ps
`include "audio_pwm_playback_sequencer_macros.svh"

module audio_pwm_playback_sequencer import apps_pkg::*; #(
	parameter int BANK_DEPTH = 512
) (
	input  logic              clk,
	input  logic              arst_n,
	apps_cmd_if.sink          cmd,
	apps_res_if.source_mp     result,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_index,
	input  logic [15:0]       cfg_wdata
);

	localparam int AW = $clog2(BANK_DEPTH);

	step_t       step;
	logic        accept;
	logic        mem_we, mem_re;
	logic [AW:0] mem_waddr, mem_raddr;
	logic [7:0]  mem_wdata, mem_rdata;

	step_t       step_s1;
	logic        valid_s1;
	logic        move_s1;
	logic [7:0]  duty_new;

	logic        out_valid_q;
	logic [7:0]  duty_q;
	logic        amp_q, play_q, reload_q, tick_q;
	logic [31:0] pos_q;

	// Handshake
	assign move_s1   = !out_valid_q || result.ready;
	assign cmd.ready = !valid_s1 || move_s1;
	assign accept    = cmd.valid && cmd.ready;

	apps_ctrl #(
		.BANK_DEPTH(BANK_DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.op           (cmd.op),
		.source       (cmd.source),
		.stream_size  (cmd.stream_size),
		.flash_sample (cmd.flash_sample),
		.bank         (cmd.bank),
		.index        (cmd.index),
		.value        (cmd.value),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.step         (step),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr)
	);

	apps_bank_mem #(
		.AW(AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we && accept),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Read stage: hold item status while the bank byte is fetched
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			step_s1 <= step;
		end
	end

	// Pick the new duty
	always_comb begin
		case (step_s1.duty_sel)
			DUTY_MID:   duty_new = MID_SCALE;
			DUTY_FLASH: duty_new = step_s1.flash;
			DUTY_MEM:   duty_new = mem_rdata;
			default:    duty_new = duty_q;
		endcase
	end

	// Output register; duty doubles as the held duty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			duty_q      <= MID_SCALE;
		end else if (move_s1) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				duty_q <= duty_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1 && valid_s1) begin
			amp_q    <= step_s1.amp_off;
			play_q   <= step_s1.playing;
			reload_q <= step_s1.reload;
			tick_q   <= step_s1.ticking;
			pos_q    <= step_s1.position;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.duty           = duty_q;
	assign result.amp_shutdown   = amp_q;
	assign result.playing        = play_q;
	assign result.reload_request = reload_q;
	assign result.position       = pos_q;
	assign result.ticking        = tick_q;

	// Checks
	`APPS_ASSERT_NEXT(a_read_feeds_s1, clk, arst_n, mem_re, valid_s1 && (step_s1.duty_sel == DUTY_MEM), "bank read without matching stage item")
	`APPS_ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !move_s1, valid_s1 && $stable(step_s1), "read stage changed while stalled")
	`APPS_ASSERT_SAME(a_reload_ticking, clk, arst_n, out_valid_q && reload_q, tick_q && !amp_q, "reload while not ticking")
	`APPS_ASSERT_SAME(a_amp_off_idle, clk, arst_n, out_valid_q && amp_q, !tick_q && !play_q, "amplifier off while active")

endmodule
